[rtl/core/hlit_pkg.sv]
// Shared types and constants for the header list item tokenizer.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package hlit_pkg;

    localparam int MAX_COMMENT_DEPTH_DEF = 15;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        SPACE_NONE    = 2'd0,
        SPACE_PENDING = 2'd1,
        SPACE_DROP    = 2'd2
    } space_mode_t;

    // Work for the back end: which of the three results an item causes, in order
    // pending space, character, item end.
    typedef struct packed {
        logic       space;
        logic       char_out;
        logic       item_end;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/core/hlit_front.sv]
// Front end: accepts bytes, tracks quote/comment/escape/space state and
// classifies each item into a command. Depends on hlit_pkg.
`default_nettype none

module hlit_front
    import hlit_pkg::*;
#(
    parameter int MAX_COMMENT_DEPTH = MAX_COMMENT_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       q_ready,
    output logic            in_ready,
    output logic            q_push,
    output cmd_t            q_cmd
);

    localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_COMMENT_DEPTH);

    logic               inside_reg,  inside_next;
    logic               esc_reg,     esc_next;
    logic               quote_reg,   quote_next;
    logic [DEPTH_W-1:0] depth_reg,   depth_next;
    space_mode_t        mode_reg,    mode_next;

    logic accept;
    logic skip;
    logic shielded;
    logic ended;
    logic space_pend;
    cmd_t cmd;

    assign in_ready   = q_ready;
    assign accept     = in_valid && q_ready;
    assign skip       = !inside_reg &&
                        (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_COMMA);
    assign shielded   = (depth_reg != '0) || quote_reg;
    assign space_pend = (mode_reg == SPACE_PENDING);

    always_comb
    begin
        inside_next  = inside_reg;
        esc_next     = esc_reg;
        quote_next   = quote_reg;
        depth_next   = depth_reg;
        mode_next    = mode_reg;
        ended        = 1'b0;
        cmd.space    = 1'b0;
        cmd.char_out = 1'b0;
        cmd.item_end = 1'b0;
        cmd.data     = in_byte;

        if (!skip)
        begin
            inside_next = 1'b1;
            if (esc_reg)
            begin
                esc_next     = 1'b0;
                cmd.char_out = 1'b1;
            end
            else
            begin
                unique case (in_byte)
                    CH_BSLASH:
                    begin
                        esc_next     = 1'b1;
                        cmd.space    = space_pend;
                        cmd.char_out = 1'b1;
                        mode_next    = SPACE_NONE;
                    end
                    CH_DQUOTE:
                    begin
                        if (depth_reg == '0)
                            quote_next = !quote_reg;
                        cmd.space    = space_pend;
                        cmd.char_out = 1'b1;
                        mode_next    = SPACE_NONE;
                    end
                    CH_LPAREN:
                    begin
                        // saturate at the nesting bound
                        if (!quote_reg && depth_reg < DEPTH_MAX)
                            depth_next = depth_reg + 1'b1;
                        cmd.space    = space_pend;
                        cmd.char_out = 1'b1;
                        mode_next    = SPACE_NONE;
                    end
                    CH_RPAREN:
                    begin
                        // drop any pending space before a closing paren
                        if (depth_reg != '0)
                            depth_next = depth_reg - 1'b1;
                        cmd.char_out = 1'b1;
                        mode_next    = SPACE_NONE;
                    end
                    CH_SPACE, CH_TAB:
                    begin
                        if (mode_reg == SPACE_NONE)
                        begin
                            if (shielded)
                                cmd.char_out = 1'b1;
                            else
                                mode_next = SPACE_PENDING;
                        end
                    end
                    CH_EQUALS, CH_SLASH, CH_SEMI:
                    begin
                        if (!shielded)
                            mode_next = SPACE_DROP;
                        cmd.char_out = 1'b1;
                    end
                    CH_COMMA:
                    begin
                        if (!shielded)
                        begin
                            cmd.item_end = 1'b1;
                            ended        = 1'b1;
                            inside_next  = 1'b0;
                            esc_next     = 1'b0;
                            quote_next   = 1'b0;
                            depth_next   = '0;
                            mode_next    = SPACE_NONE;
                        end
                        else
                        begin
                            cmd.space    = space_pend;
                            cmd.char_out = 1'b1;
                            mode_next    = SPACE_NONE;
                        end
                    end
                    default:
                    begin
                        cmd.space    = space_pend;
                        cmd.char_out = 1'b1;
                        mode_next    = SPACE_NONE;
                    end
                endcase
            end

            // close whatever is open at the end of the field
            if (in_last)
            begin
                if (!ended)
                    cmd.item_end = 1'b1;
                inside_next = 1'b0;
                esc_next    = 1'b0;
                quote_next  = 1'b0;
                depth_next  = '0;
                mode_next   = SPACE_NONE;
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.space || cmd.char_out || cmd.item_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            esc_reg    <= 1'b0;
            quote_reg  <= 1'b0;
            depth_reg  <= '0;
            mode_reg   <= SPACE_NONE;
        end
        else if (accept)
        begin
            inside_reg <= inside_next;
            esc_reg    <= esc_next;
            quote_reg  <= quote_next;
            depth_reg  <= depth_next;
            mode_reg   <= mode_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hlit_queue.sv]
// Short command queue between front and back ends.
// Depends on hlit_pkg for cmd_t and QUEUE_DEPTH.
`default_nettype none

module hlit_queue
    import hlit_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/hlit_back.sv]
// Back end: expands each command into up to three results, one per cycle
// while out_ready is high, from a registered output stage. Depends on hlit_pkg.
`default_nettype none

module hlit_back
    import hlit_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      out_byte_valid,
    output logic [7:0] out_byte,
    output logic      out_item_end
);

    cmd_t cur_reg, cur_next;
    cmd_t rest;
    logic out_accept;
    logic rest_empty;

    assign out_valid  = cur_reg.space || cur_reg.char_out || cur_reg.item_end;
    assign out_accept = out_valid && out_ready;

    // what is left of the current command once the front result is taken
    always_comb
    begin
        rest = cur_reg;
        priority if (cur_reg.space)
            rest.space = 1'b0;
        else if (cur_reg.char_out)
            rest.char_out = 1'b0;
        else
            rest.item_end = 1'b0;
    end

    assign rest_empty = !(rest.space || rest.char_out || rest.item_end);
    assign q_pop      = q_valid && (!out_valid || (out_accept && rest_empty));

    always_comb
    begin
        cur_next = cur_reg;
        if (q_pop)
            cur_next = q_cmd;
        else if (out_accept)
            cur_next = rest;
    end

    always_comb
    begin
        out_byte_valid = 1'b0;
        out_byte       = 8'h00;
        out_item_end   = 1'b0;
        priority if (cur_reg.space)
        begin
            out_byte_valid = 1'b1;
            out_byte       = CH_SPACE;
        end
        else if (cur_reg.char_out)
        begin
            out_byte_valid = 1'b1;
            out_byte       = cur_reg.data;
        end
        else if (cur_reg.item_end)
            out_item_end = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else
            cur_reg <= cur_next;
    end

endmodule

`default_nettype wire

[rtl/core/header_list_item_tokenizer.sv]
// Top level of the header list item tokenizer: front end, command queue, back end.
// Depends on hlit_pkg, hlit_front, hlit_queue and hlit_back.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata[7:0] in_byte, tlast field_end
//  m_axis   | out | tdata[0] byte_valid, tdata[8:1] out_byte, tlast item_end
//
// One input item is accepted per cycle while the command queue has room; the
// back end delivers one result per cycle while the receiver is ready, up to three
// per item. The two-entry command queue lets the front keep taking bytes while the
// output is stalled, until the queue is full. An accepted byte passes a queue slot
// and the back end's output register. rst_n clears all state at once; no clearing pass is needed.
`default_nettype none

module header_list_item_tokenizer
    import hlit_pkg::*;
#(
    parameter int MAX_COMMENT_DEPTH = MAX_COMMENT_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // field_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [0] byte_valid, [8:1] out_byte, rest zero
    output logic             m_axis_tlast    // item_end
);

    logic       q_ready;
    logic       q_push;
    cmd_t       push_cmd;
    logic       q_valid;
    logic       q_pop;
    cmd_t       pop_cmd;
    logic       res_byte_valid;
    logic [7:0] res_byte;

    hlit_front #(
        .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_ready  (q_ready),
        .in_ready (s_axis_tready),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    hlit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (pop_cmd)
    );

    hlit_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cmd          (pop_cmd),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte_valid (res_byte_valid),
        .out_byte       (res_byte),
        .out_item_end   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, res_byte, res_byte_valid};

endmodule

`default_nettype wire

[verif/header_list_item_tokenizer_tb.sv]
// Self-checking testbench for header_list_item_tokenizer: stream in, stream out.
// A directed table, some rows typed in, then random header fields are checked against a built-in tokenizer.
// Depends on hlit_pkg and the RTL of header_list_item_tokenizer only.
`default_nettype none

module header_list_item_tokenizer_tb;

    import hlit_pkg::*;

    localparam int PREDICT        = -1;
    localparam int RANDOM_ITEMS   = 350;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       item_end;
    } tok_res_t;

    // n_typed is the number of results typed in, or PREDICT to use the tokenizer model
    typedef struct packed {
        logic [7:0]       in_byte;
        logic             field_end;
        int               n_typed;
        tok_res_t [0:1]   typed_res;
    } dir_row_t;

    localparam tok_res_t       NO_RES  = '0;
    localparam tok_res_t [0:1] NO_PAIR = '0;
    localparam tok_res_t       END_RES = '{1'b0, 8'h00, 1'b1};

    localparam dir_row_t DIRECTED_ROWS [29] = '{
        '{CH_SPACE,  1'b0, 0,       NO_PAIR},
        '{CH_TAB,    1'b0, 0,       NO_PAIR},
        '{CH_COMMA,  1'b0, 0,       NO_PAIR},
        '{8'h00,     1'b0, 1,       '{'{1'b1, 8'h00, 1'b0}, NO_RES}},
        '{CH_TAB,    1'b0, PREDICT, NO_PAIR},
        '{CH_SPACE,  1'b0, PREDICT, NO_PAIR},
        '{8'hFF,     1'b0, 2,       '{'{1'b1, CH_SPACE, 1'b0}, '{1'b1, 8'hFF, 1'b0}}},
        '{CH_SLASH,  1'b0, PREDICT, NO_PAIR},
        '{CH_SPACE,  1'b0, PREDICT, NO_PAIR},
        '{CH_SEMI,   1'b0, PREDICT, NO_PAIR},
        '{CH_EQUALS, 1'b0, PREDICT, NO_PAIR},
        '{CH_BSLASH, 1'b0, PREDICT, NO_PAIR},
        '{CH_COMMA,  1'b0, PREDICT, NO_PAIR},
        '{CH_DQUOTE, 1'b0, PREDICT, NO_PAIR},
        '{CH_TAB,    1'b0, PREDICT, NO_PAIR},
        '{CH_LPAREN, 1'b0, PREDICT, NO_PAIR},
        '{CH_COMMA,  1'b0, PREDICT, NO_PAIR},
        '{CH_DQUOTE, 1'b0, PREDICT, NO_PAIR},
        '{CH_LPAREN, 1'b0, PREDICT, NO_PAIR},
        '{CH_RPAREN, 1'b0, PREDICT, NO_PAIR},
        '{CH_RPAREN, 1'b0, PREDICT, NO_PAIR},
        '{CH_SPACE,  1'b0, PREDICT, NO_PAIR},
        '{CH_RPAREN, 1'b0, PREDICT, NO_PAIR},
        '{CH_SPACE,  1'b0, PREDICT, NO_PAIR},
        '{CH_COMMA,  1'b1, 1,       '{END_RES, NO_RES}},
        '{CH_SPACE,  1'b1, 0,       NO_PAIR},
        '{CH_LPAREN, 1'b0, PREDICT, NO_PAIR},
        '{CH_DQUOTE, 1'b0, PREDICT, NO_PAIR},
        '{CH_BSLASH, 1'b1, 2,       '{'{1'b1, CH_BSLASH, 1'b0}, END_RES}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;    // field_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [0] byte_valid, [8:1] out_byte, rest zero
    logic        m_axis_tlast;           // item_end

    header_list_item_tokenizer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // tokenizer model state
    bit          tk_in_item;
    bit          tk_escape;
    bit          tk_quote;
    int          tk_depth;
    space_mode_t tk_space;
    bit          skipped_byte;
    int          deepest;

    tok_res_t    fresh_results[$];
    tok_res_t    pending_results[$];
    logic [7:0]  field_buf[$];

    int          errors;
    int          bytes_sent;
    int          useful_bytes;
    int          results_checked;
    int          ends_checked;
    int          fields_sent;
    int          quiet_cycles;
    int          hold_left;
    bit          hold_off_req;
    bit          hold_done;
    bit          send_calm;
    bit          recv_calm;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_cycles(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_tokenizer();
        tk_in_item = 1'b0;
        tk_escape  = 1'b0;
        tk_quote   = 1'b0;
        tk_depth   = 0;
        tk_space   = SPACE_NONE;
    endfunction

    function automatic void put_res(input logic v, input logic [7:0] b, input logic e);
        fresh_results.push_back('{v, b, e});
    endfunction

    function automatic void put_space();
        if (tk_space == SPACE_PENDING)
            put_res(1'b1, CH_SPACE, 1'b0);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c, input logic fend);
        bit ended;
        bit shielded;
        ended = 1'b0;
        skipped_byte = 1'b0;
        if (!tk_in_item) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_COMMA) begin
                skipped_byte = 1'b1;
                return;
            end
            clear_tokenizer();
            tk_in_item = 1'b1;
        end
        shielded = (tk_depth != 0) || tk_quote;

        if (tk_escape) begin
            tk_escape = 1'b0;
            put_res(1'b1, c, 1'b0);
        end
        else begin
            case (c)
                CH_BSLASH:
                begin
                    tk_escape = 1'b1;
                    put_space();
                    put_res(1'b1, c, 1'b0);
                    tk_space = SPACE_NONE;
                end
                CH_DQUOTE:
                begin
                    if (tk_depth == 0)
                        tk_quote = !tk_quote;
                    put_space();
                    put_res(1'b1, c, 1'b0);
                    tk_space = SPACE_NONE;
                end
                CH_LPAREN:
                begin
                    // saturate at the nesting bound
                    if (!tk_quote && tk_depth < MAX_COMMENT_DEPTH_DEF)
                        tk_depth++;
                    put_space();
                    put_res(1'b1, c, 1'b0);
                    tk_space = SPACE_NONE;
                end
                CH_RPAREN:
                begin
                    // no space before ')'
                    if (tk_depth != 0)
                        tk_depth--;
                    put_res(1'b1, c, 1'b0);
                    tk_space = SPACE_NONE;
                end
                CH_SPACE, CH_TAB:
                begin
                    if (tk_space == SPACE_NONE) begin
                        if (shielded)
                            put_res(1'b1, c, 1'b0);
                        else
                            tk_space = SPACE_PENDING;
                    end
                end
                CH_EQUALS, CH_SLASH, CH_SEMI:
                begin
                    if (!shielded)
                        tk_space = SPACE_DROP;
                    put_res(1'b1, c, 1'b0);
                end
                CH_COMMA:
                begin
                    if (!shielded) begin
                        put_res(1'b0, 8'h00, 1'b1);
                        clear_tokenizer();
                        ended = 1'b1;
                    end
                    else begin
                        put_space();
                        put_res(1'b1, c, 1'b0);
                        tk_space = SPACE_NONE;
                    end
                end
                default:
                begin
                    put_space();
                    put_res(1'b1, c, 1'b0);
                    tk_space = SPACE_NONE;
                end
            endcase
        end
        if (tk_depth > deepest)
            deepest = tk_depth;

        if (fend) begin
            if (!ended && tk_in_item)
                put_res(1'b0, 8'h00, 1'b1);
            clear_tokenizer();
        end
    endfunction

    // Offer one item, wait for its handshake, then queue what it should produce.
    task automatic send_item(input logic [7:0] b, input logic fend, input int n_typed,
                             input tok_res_t [0:1] typed_res);
        int gap;
        int i;
        gap = idle_cycles(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fend;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        tokenize_byte(b, fend);
        if (n_typed == PREDICT) begin
            foreach (fresh_results[k])
                pending_results.push_back(fresh_results[k]);
        end
        else begin
            for (i = 0; i < n_typed; i++)
                pending_results.push_back(typed_res[i]);
        end
        fresh_results.delete();
        bytes_sent++;
        if (!skipped_byte)
            useful_bytes++;
        @(posedge clk);
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 5))
            0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
            3:       return 8'h30 + 8'($urandom_range(0, 9));
            4:       return 8'h41 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(0, 2))
            0:       return CH_EQUALS;
            1:       return CH_SLASH;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic void add_inner(input bit parens);
        case ($urandom_range(0, parens ? 7 : 5))
            0, 1: field_buf.push_back(word_char());
            2:    field_buf.push_back(blank());
            3:    field_buf.push_back(CH_COMMA);
            4:    field_buf.push_back(pick_sep());
            5:
            begin
                field_buf.push_back(CH_BSLASH);
                field_buf.push_back(8'($urandom));
            end
            6:    field_buf.push_back(CH_LPAREN);
            default: field_buf.push_back(CH_RPAREN);
        endcase
    endfunction

    function automatic void add_comment(input int levels);
        repeat (levels) begin
            field_buf.push_back(CH_LPAREN);
            if ($urandom_range(0, 2) == 0)
                add_inner(1'b0);
        end
        repeat (levels) begin
            field_buf.push_back(CH_RPAREN);
            if ($urandom_range(0, 3) == 0)
                add_inner(1'b0);
        end
    endfunction

    function automatic void add_token();
        case ($urandom_range(0, 11))
            0, 1, 2: repeat ($urandom_range(1, 5)) field_buf.push_back(word_char());
            3, 4:    repeat ($urandom_range(1, 3)) field_buf.push_back(blank());
            5:
            begin
                field_buf.push_back(pick_sep());
                if ($urandom_range(0, 1))
                    field_buf.push_back(blank());
            end
            6, 7:
            begin
                field_buf.push_back(CH_DQUOTE);
                repeat ($urandom_range(0, 6)) add_inner(1'b1);
                field_buf.push_back(CH_DQUOTE);
            end
            8, 9:
            begin
                if ($urandom_range(0, 7) == 0)
                    add_comment($urandom_range(MAX_COMMENT_DEPTH_DEF - 1,
                                               MAX_COMMENT_DEPTH_DEF + 3));
                else
                    add_comment($urandom_range(1, 3));
            end
            10:
            begin
                field_buf.push_back(CH_BSLASH);
                field_buf.push_back(8'($urandom));
            end
            default: field_buf.push_back(8'($urandom));
        endcase
    endfunction

    // Mostly well-formed lists; some raw noise and some fields cut short.
    function automatic void build_field(input bit deep);
        int n_items;
        int i;
        int keep;
        field_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) field_buf.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                field_buf.push_back($urandom_range(0, 2) == 0 ? CH_COMMA : blank());
        n_items = $urandom_range(1, 4);
        for (i = 0; i < n_items; i++) begin
            if (i == 0 && deep)
                add_comment(MAX_COMMENT_DEPTH_DEF + 2);
            repeat ($urandom_range(1, 5)) add_token();
            if (i < n_items - 1 || $urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1))
                    field_buf.push_back(blank());
                field_buf.push_back(CH_COMMA);
                if ($urandom_range(0, 1))
                    field_buf.push_back(blank());
            end
        end
        if ($urandom_range(0, 9) == 0 && field_buf.size() > 1) begin
            keep = $urandom_range(1, field_buf.size() - 1);
            while (field_buf.size() > keep)
                void'(field_buf.pop_back());
        end
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else begin
                m_axis_tready <= 1'b1;
                hold_left = idle_cycles(recv_calm);
            end
        end
    end

    always @(negedge clk)
    begin
        tok_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: byte_valid %0b out_byte %02h item_end %0b",
                       m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tlast);
                errors++;
            end
            else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.byte_valid) begin
                    $error("byte_valid: expected %0b, got %0b", want.byte_valid,
                           m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[8:1] !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte,
                           m_axis_tdata[8:1]);
                    errors++;
                end
                if (m_axis_tlast !== want.item_end) begin
                    $error("item_end: expected %0b, got %0b", want.item_end, m_axis_tlast);
                    errors++;
                end
                results_checked++;
                if (want.item_end)
                    ends_checked++;
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    initial
    begin
        forever begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        clear_tokenizer();
        send_calm = 1'b0;
        recv_calm = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r])
            send_item(DIRECTED_ROWS[r].in_byte, DIRECTED_ROWS[r].field_end,
                      DIRECTED_ROWS[r].n_typed, DIRECTED_ROWS[r].typed_res);

        useful_bytes = 0;
        while (useful_bytes < RANDOM_ITEMS) begin
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            // first field gets a comment nested past the depth bound, unless it is raw noise
            build_field(fields_sent == 0);
            for (i = 0; i < field_buf.size(); i++)
                send_item(field_buf[i], i == field_buf.size() - 1, PREDICT, NO_PAIR);
            fields_sent++;
            // let the block fill up behind a stalled receiver
            if (!hold_done && useful_bytes >= 120) begin
                hold_off_req = 1'b1;
                hold_done = 1'b1;
                send_calm = 1'b1;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes sent (%0d random fields), %0d results checked, %0d item ends",
                 bytes_sent, fields_sent, results_checked, ends_checked);
        $display("deepest comment nesting %0d of %0d, long receiver hold-off done: %0b",
                 deepest, MAX_COMMENT_DEPTH_DEF, hold_done);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
